// ----- rtl/core/wsd_pkg.sv -----
// shared types, codes and helper functions for the wav stream sample decoder
// no dependencies
`default_nettype none

package wsd_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RIFF      = 3'd1;
    localparam logic [2:0] ERR_WAVE      = 3'd2;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
    localparam logic [2:0] ERR_FMT_SHORT = 3'd4;
    localparam logic [2:0] ERR_FORMAT    = 3'd5;
    localparam logic [2:0] ERR_NO_FMT    = 3'd6;
    localparam logic [2:0] ERR_TRUNC     = 3'd7;

    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_PCM24 = 2'd1;
    localparam logic [1:0] FMT_FLT32 = 2'd2;
    localparam logic [1:0] FMT_BAD   = 2'd3;

    localparam logic [31:0] ID_RIFF   = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE   = 32'h4556_4157;
    localparam logic [31:0] ID_FMT    = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA   = 32'h6174_6164;
    localparam logic [31:0] MAX_CHUNK = 32'h0800_0000;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [23:0] sample_value;
        logic [15:0]        channel_index;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [1:0]         sample_format;
        logic [2:0]         fault_code;
    } res_t;

    typedef struct packed {
        logic step;
        logic finish;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic       need_div;
        logic [1:0] new_cnt;
        logic       div_done;
        logic       last_pop;
        logic [1:0] res_cnt;
    } sts_t;

    function automatic logic [1:0] format_code(input logic [15:0] afmt,
                                               input logic [15:0] bits);
        logic [1:0] f;
        if (afmt == 16'd1 && bits == 16'd16)
            f = FMT_PCM16;
        else if (afmt == 16'd1 && bits == 16'd24)
            f = FMT_PCM24;
        else if (afmt == 16'd3 && bits == 16'd32)
            f = FMT_FLT32;
        else
            f = FMT_BAD;
        return f;
    endfunction

    // float32 to q1.23, truncating toward zero with saturation
    function automatic logic [23:0] float_to_q23(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [7:0]  sh;
        logic [23:0] mag;
        logic [23:0] r;
        e   = b[30:23];
        m   = b[22:0];
        sh  = 8'd127 - e;
        mag = {1'b1, m} >> sh[4:0];
        if (e == 8'hFF && m != 23'd0)
            r = 24'd0;
        else if (e >= 8'd127)
            r = b[31] ? 24'h80_0000 : 24'h7F_FFFF;
        else if (e == 8'd0)
            r = 24'd0;
        else if (sh >= 8'd24)
            r = 24'd0;
        else
            r = b[31] ? (24'd0 - mag) : mag;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wsd_if.sv -----
// channel interfaces of the wav stream sample decoder
// no dependencies
`default_nettype none

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wsd_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [23:0] sample_value;
    logic [15:0]        channel_index;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [1:0]         sample_format;
    logic [2:0]         fault_code;
    logic               last_in_run;
    modport source (output valid, output result_kind, output sample_value,
                    output channel_index, output channel_count, output sample_rate,
                    output sample_format, output fault_code, output last_in_run,
                    input ready);
    modport sink (input valid, input result_kind, input sample_value,
                  input channel_index, input channel_count, input sample_rate,
                  input sample_format, input fault_code, input last_in_run,
                  output ready);
endinterface

interface wsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] file_length_bytes;
    modport source (output valid, output file_length_bytes, input ready);
    modport sink (input valid, input file_length_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wsd_div.sv -----
// bit-serial remainder unit, one quotient bit per cycle
// depends on nothing
`default_nettype none

module wsd_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [17:0] divisor,
    output logic             done,
    output logic             rem_zero
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [17:0] dvs_reg, dvs_next;
    logic [17:0] rem_reg, rem_next;
    logic [18:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = 18'd0;
        end
        else if (busy_reg)
        begin
            // restoring step
            if (trial >= {1'b0, dvs_reg})
                rem_next = 18'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[17:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == 18'd0);

endmodule

`default_nettype wire

// ----- rtl/core/wsd_dp.sv -----
// parse state, chunk walking, sample conversion and result queue
// depends on wsd_pkg and wsd_div
`default_nettype none

module wsd_dp
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output sts_t             st,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    output res_t             cur_res,
    output logic             cur_last
);

    localparam logic [3:0] PH_RIFF  = 4'd0;
    localparam logic [3:0] PH_RSIZE = 4'd1;
    localparam logic [3:0] PH_WAVE  = 4'd2;
    localparam logic [3:0] PH_HDR   = 4'd3;
    localparam logic [3:0] PH_FMT   = 4'd4;
    localparam logic [3:0] PH_DATA  = 4'd5;
    localparam logic [3:0] PH_SKIP  = 4'd6;
    localparam logic [3:0] PH_PAD   = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;
    localparam logic [3:0] PH_ERR   = 4'd9;

    logic [31:0] flen_reg, flen_next;
    logic [3:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] hshift_reg, hshift_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic        pad_reg, pad_next;
    logic [15:0] afmt_reg, afmt_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] sshift_reg, sshift_next;
    logic [1:0]  scnt_reg, scnt_next;
    logic [15:0] chcnt_reg, chcnt_next;
    logic        last_pend_reg, last_pend_next;
    res_t        q_reg [2];
    res_t        q_next [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        head_reg, head_next;

    res_t        rr [2];
    logic [1:0]  n;
    logic        need_div;
    logic        div_done;
    logic        div_rem_zero;
    logic [17:0] frame;
    logic [31:0] remaining;
    logic        too_big;
    logic [31:0] skip;
    logic [31:0] off;
    logic [2:0]  cnt3;
    logic [23:0] sval;
    logic [16:0] ch_inc;
    logic [1:0]  fcode;
    logic        last_in;
    res_t        info_res;
    res_t        plain_res;

    assign fcode = format_code(afmt_reg, bits_reg);
    assign frame = 18'({2'b00, chans_reg} * {15'd0, bits_reg[5:3]});

    always_comb
    begin
        plain_res = '0;
        info_res               = '0;
        info_res.result_kind   = KIND_INFO;
        info_res.channel_count = chans_reg;
        info_res.sample_rate   = rate_reg;
        info_res.sample_format = fcode;
    end

    always_comb
    begin
        flen_next      = cfg_we ? cfg_data : flen_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        hshift_next    = hshift_reg;
        hcnt_next      = hcnt_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        pad_next       = pad_reg;
        afmt_next      = afmt_reg;
        chans_next     = chans_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        fmt_seen_next  = fmt_seen_reg;
        sshift_next    = sshift_reg;
        scnt_next      = scnt_reg;
        chcnt_next     = chcnt_reg;
        last_pend_next = last_pend_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        rr[0]          = '0;
        rr[1]          = '0;
        n              = 2'd0;
        need_div       = 1'b0;
        remaining      = 32'd0;
        too_big        = 1'b0;
        skip           = 32'd0;
        off            = 32'd0;
        cnt3           = 3'd0;
        sval           = 24'd0;
        ch_inc         = 17'd0;
        last_in        = 1'b0;

        if (cmd.step && phase_reg != PH_DONE && phase_reg != PH_ERR)
        begin
            last_in  = last_byte;
            pos_next = (pos_reg != 32'hFFFF_FFFF) ? pos_reg + 32'd1 : pos_reg;
            hshift_next = {byte_value, hshift_reg[31:8]};
            remaining = (pos_next <= flen_reg) ? flen_reg - pos_next : 32'd0;
            unique case (phase_reg)
                PH_RIFF, PH_RSIZE, PH_WAVE:
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_next >= 4'd4)
                    begin
                        hcnt_next = 4'd0;
                        if (phase_reg == PH_RIFF)
                        begin
                            if (hshift_next != ID_RIFF)
                            begin
                                rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0,
                                             2'd0, ERR_RIFF};
                                n = n + 2'd1;
                                phase_next = PH_ERR;
                            end
                            else
                                phase_next = PH_RSIZE;
                        end
                        else if (phase_reg == PH_RSIZE)
                            phase_next = PH_WAVE;
                        else if (hshift_next != ID_WAVE)
                        begin
                            rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0,
                                         2'd0, ERR_WAVE};
                            n = n + 2'd1;
                            phase_next = PH_ERR;
                        end
                        else
                            phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_next == 4'd4)
                        id_next = hshift_next;
                    if (hcnt_next >= 4'd8)
                    begin
                        hcnt_next = 4'd0;
                        len_next  = hshift_next;
                        too_big   = (len_next > remaining) || (len_next > MAX_CHUNK);
                        if (id_reg == ID_FMT)
                        begin
                            if (too_big || len_next == 32'd0)
                            begin
                                rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0,
                                             2'd0, too_big ? ERR_TOO_LARGE : ERR_FMT_SHORT};
                                n = n + 2'd1;
                                phase_next = PH_ERR;
                            end
                            else
                            begin
                                left_next  = len_next;
                                phase_next = PH_FMT;
                            end
                        end
                        else if (id_reg == ID_DATA)
                        begin
                            if (!fmt_seen_reg || too_big || chans_reg == 16'd0 ||
                                fcode == FMT_BAD)
                            begin
                                rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0,
                                             2'd0, !fmt_seen_reg ? ERR_NO_FMT :
                                             (too_big ? ERR_TOO_LARGE : ERR_FORMAT)};
                                n = n + 2'd1;
                                phase_next = PH_ERR;
                            end
                            else
                            begin
                                // whole-frame check runs in the remainder unit
                                need_div       = 1'b1;
                                last_pend_next = last_byte;
                            end
                        end
                        else
                        begin
                            skip     = (len_next < remaining) ? len_next : remaining;
                            pad_next = !too_big && len_next[0];
                            if (skip == 32'd0)
                                phase_next = pad_next ? PH_PAD : PH_HDR;
                            else
                            begin
                                left_next  = skip;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    off = len_reg - left_reg;
                    if (off == 32'd0)
                        afmt_next[7:0] = byte_value;
                    else if (off == 32'd1)
                        afmt_next[15:8] = byte_value;
                    else if (off == 32'd2)
                        chans_next[7:0] = byte_value;
                    else if (off == 32'd3)
                        chans_next[15:8] = byte_value;
                    else if (off == 32'd4)
                        rate_next[7:0] = byte_value;
                    else if (off == 32'd5)
                        rate_next[15:8] = byte_value;
                    else if (off == 32'd6)
                        rate_next[23:16] = byte_value;
                    else if (off == 32'd7)
                        rate_next[31:24] = byte_value;
                    else if (off == 32'd14)
                        bits_next[7:0] = byte_value;
                    else if (off == 32'd15)
                        bits_next[15:8] = byte_value;
                    left_next = left_reg - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        if (len_reg < 32'd16)
                        begin
                            rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0,
                                         2'd0, ERR_FMT_SHORT};
                            n = n + 2'd1;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            fmt_seen_next = 1'b1;
                            pad_next      = len_reg[0];
                            hcnt_next     = 4'd0;
                            phase_next    = len_reg[0] ? PH_PAD : PH_HDR;
                        end
                    end
                end
                PH_DATA:
                begin
                    cnt3        = {1'b0, scnt_reg} + 3'd1;
                    sshift_next = sshift_reg | (32'(byte_value) << {scnt_reg, 3'b000});
                    if ({13'd0, cnt3} >= {3'd0, bits_reg[15:3]})
                    begin
                        unique case (fcode)
                            FMT_PCM16: sval = {sshift_next[15:0], 8'h00};
                            FMT_PCM24: sval = sshift_next[23:0];
                            FMT_FLT32: sval = float_to_q23(sshift_next);
                            default:   sval = 24'd0;
                        endcase
                        rr[n[0]] = '{KIND_SAMPLE, sval, chcnt_reg, 16'd0, 32'd0,
                                     2'd0, ERR_NONE};
                        n = n + 2'd1;
                        ch_inc = {1'b0, chcnt_reg} + 17'd1;
                        chcnt_next  = (ch_inc >= {1'b0, chans_reg}) ? 16'd0 : ch_inc[15:0];
                        sshift_next = 32'd0;
                        scnt_next   = 2'd0;
                    end
                    else
                        scnt_next = cnt3[1:0];
                    left_next = left_reg - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        rr[n[0]] = '{KIND_DONE, 24'sd0, 16'd0, 16'd0, 32'd0,
                                     2'd0, ERR_NONE};
                        n = n + 2'd1;
                        phase_next = PH_DONE;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        hcnt_next  = 4'd0;
                        phase_next = pad_reg ? PH_PAD : PH_HDR;
                    end
                end
                PH_PAD:
                begin
                    pad_next   = 1'b0;
                    hcnt_next  = 4'd0;
                    phase_next = PH_HDR;
                end
                default:
                    phase_next = PH_ERR;
            endcase
        end
        else if (cmd.finish)
        begin
            last_in = last_pend_reg;
            if (!div_rem_zero)
            begin
                rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0, 2'd0, ERR_FORMAT};
                n = n + 2'd1;
                phase_next = PH_ERR;
            end
            else
            begin
                rr[n[0]] = info_res;
                n = n + 2'd1;
                sshift_next = 32'd0;
                scnt_next   = 2'd0;
                chcnt_next  = 16'd0;
                if (len_reg == 32'd0)
                begin
                    rr[n[0]] = '{KIND_DONE, 24'sd0, 16'd0, 16'd0, 32'd0, 2'd0, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    left_next  = len_reg;
                    phase_next = PH_DATA;
                end
            end
        end

        // truncated file: error follows whatever this byte produced
        if (!need_div && last_in && phase_next != PH_DONE && phase_next != PH_ERR)
        begin
            rr[n[0]] = '{KIND_ERROR, 24'sd0, 16'd0, 16'd0, 32'd0, 2'd0, ERR_TRUNC};
            n = n + 2'd1;
            phase_next = PH_ERR;
        end

        if (n != 2'd0)
        begin
            q_next    = rr;
            cnt_next  = n;
            head_next = 1'b0;
        end
        else if (cmd.pop)
        begin
            if ({1'b0, head_reg} == cnt_reg - 2'd1)
            begin
                cnt_next  = 2'd0;
                head_next = 1'b0;
            end
            else
                head_next = 1'b1;
        end
    end

    wsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (need_div),
        .dividend (len_next),
        .divisor  (frame),
        .done     (div_done),
        .rem_zero (div_rem_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg      <= 32'd0;
            phase_reg     <= PH_RIFF;
            pos_reg       <= 32'd0;
            hshift_reg    <= 32'd0;
            hcnt_reg      <= 4'd0;
            id_reg        <= 32'd0;
            len_reg       <= 32'd0;
            left_reg      <= 32'd0;
            pad_reg       <= 1'b0;
            afmt_reg      <= 16'd0;
            chans_reg     <= 16'd0;
            rate_reg      <= 32'd0;
            bits_reg      <= 16'd0;
            fmt_seen_reg  <= 1'b0;
            sshift_reg    <= 32'd0;
            scnt_reg      <= 2'd0;
            chcnt_reg     <= 16'd0;
            last_pend_reg <= 1'b0;
            cnt_reg       <= 2'd0;
            head_reg      <= 1'b0;
        end
        else
        begin
            flen_reg      <= flen_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hshift_reg    <= hshift_next;
            hcnt_reg      <= hcnt_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            pad_reg       <= pad_next;
            afmt_reg      <= afmt_next;
            chans_reg     <= chans_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            fmt_seen_reg  <= fmt_seen_next;
            sshift_reg    <= sshift_next;
            scnt_reg      <= scnt_next;
            chcnt_reg     <= chcnt_next;
            last_pend_reg <= last_pend_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign cur_res  = (cnt_reg != 2'd0) ? q_reg[head_reg] : plain_res;
    assign cur_last = ({1'b0, head_reg} == cnt_reg - 2'd1);

    assign st.need_div = need_div;
    assign st.new_cnt  = n;
    assign st.div_done = div_done;
    assign st.last_pop = cur_last;
    assign st.res_cnt  = cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/core/wsd_ctrl.sv -----
// handshake controller: accept, wait for frame check, deliver results
// depends on wsd_pkg
`default_nettype none

module wsd_ctrl
    import wsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  wire sts_t st
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cmd.step   = in_ready && in_valid;
    assign cmd.finish = (state_reg == S_DIV) && st.div_done;
    assign cmd.pop    = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.need_div)
                        state_next = S_DIV;
                    else if (st.new_cnt != 2'd0)
                        state_next = S_OUT;
                end
            end
            S_DIV:
                if (st.div_done)
                    state_next = S_OUT;
            S_OUT:
                if (out_ready && st.last_pop)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_out_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> st.res_cnt != 2'd0)
        else $error("result offered with empty queue");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && st.need_div |=> state_reg == S_DIV)
        else $error("frame check not started");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> st.res_cnt == 2'd0)
        else $error("undelivered results while accepting");

endmodule

`default_nettype wire

// ----- rtl/core/wav_stream_sample_decoder.sv -----
// top level of the wav stream sample decoder
// depends on wsd_pkg, wsd_if, wsd_ctrl, wsd_dp (which holds wsd_div)
// latency: a byte is parsed in the cycle it is accepted; its results follow from the next cycle, but a valid
// data chunk header yields its results only after the frame check. throughput: one byte per cycle when it
// yields no result, else no new byte is taken until every result is delivered; the check is bit-serial
// reset: rst_n asynchronous active low clears the parse state and the file length register
`default_nettype none

module wav_stream_sample_decoder
    import wsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_byte_if.sink  byte_stream,
    wsd_res_if.source result_stream,
    wsd_cfg_if.sink   cfg_write
);

    cmd_t cmd;
    sts_t st;
    res_t cur_res;
    logic cur_last;

    // config writes are taken at any time; they are to be done only while idle, and the block does not enforce this
    assign cfg_write.ready = 1'b1;

    // controller: one transaction at a time on each side
    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_stream.valid),
        .in_ready  (byte_stream.ready),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .cmd       (cmd),
        .st        (st)
    );

    // datapath: chunk walker, converters and two-entry result queue
    wsd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .byte_value (byte_stream.byte_value),
        .last_byte  (byte_stream.last_byte),
        .cfg_we     (cfg_write.valid),
        .cfg_data   (cfg_write.file_length_bytes),
        .cur_res    (cur_res),
        .cur_last   (cur_last)
    );

    // result payload straight from the queue head
    assign result_stream.result_kind   = cur_res.result_kind;
    assign result_stream.sample_value  = cur_res.sample_value;
    assign result_stream.channel_index = cur_res.channel_index;
    assign result_stream.channel_count = cur_res.channel_count;
    assign result_stream.sample_rate   = cur_res.sample_rate;
    assign result_stream.sample_format = cur_res.sample_format;
    assign result_stream.fault_code    = cur_res.fault_code;
    assign result_stream.last_in_run   = cur_last;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for wav_stream_sample_decoder: sends one generated wav file and checks each result
// depends on wsd_pkg, wsd_if and the decoder rtl
`default_nettype none

module tb;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;

    typedef enum logic [3:0] {
        P_RIFF, P_RSIZE, P_WAVE, P_HDR, P_FMT, P_DATA, P_SKIP, P_PAD, P_DONE, P_ERR
    } parse_phase_t;

    typedef struct packed {
        res_t r;
        logic last;
    } decoded_t;

    // decoder behavior model plus the queue of results still owed by the block
    class wav_scoreboard;
        decoded_t     owed[$];
        int           mismatches;
        logic [31:0]  file_len;
        parse_phase_t phase;
        logic [31:0]  pos, hshift, chunk_id, chunk_len, left, sshift;
        logic [2:0]   hcount;
        logic         pad, fmt_ok;
        logic [15:0]  afmt, chans, bits, chan_ctr;
        logic [31:0]  rate;
        logic [1:0]   scount;

        function new();
            mismatches = 0;
            file_len = 0;
            phase = P_RIFF;
            pos = 0; hshift = 0; chunk_id = 0; chunk_len = 0; left = 0; sshift = 0;
            hcount = 0; pad = 0; fmt_ok = 0;
            afmt = 0; chans = 0; bits = 0; chan_ctr = 0; rate = 0; scount = 0;
        endfunction

        function logic [1:0] fmt_kind();
            if (afmt == 16'd1 && bits == 16'd16) return FMT_PCM16;
            if (afmt == 16'd1 && bits == 16'd24) return FMT_PCM24;
            if (afmt == 16'd3 && bits == 16'd32) return FMT_FLT32;
            return FMT_BAD;
        endfunction

        function void emit(logic [1:0] kind, logic [23:0] v, logic [15:0] ch, bit info,
                           logic [2:0] err);
            decoded_t d;
            d = '0;
            d.r.result_kind = kind;
            d.r.sample_value = v;
            d.r.channel_index = ch;
            if (info)
            begin
                d.r.channel_count = chans;
                d.r.sample_rate = rate;
                d.r.sample_format = fmt_kind();
            end
            d.r.fault_code = err;
            owed.push_back(d);
        endfunction

        function void abort(logic [2:0] err);
            emit(KIND_ERROR, 24'd0, 16'd0, 0, err);
            phase = P_ERR;
        endfunction

        function void body_done();
            phase = pad ? P_PAD : P_HDR;
            hcount = 0;
        endfunction

        function logic [23:0] float_q23(logic [31:0] w);
            logic [7:0]  e;
            logic [31:0] mag, sh;
            e = w[30:23];
            if (e == 8'hFF && w[22:0] != 0) return 24'd0;
            if (e >= 8'd127) return w[31] ? 24'h800000 : 24'h7FFFFF;
            if (e == 0) return 24'd0;
            sh = 32'd127 - e;
            if (sh >= 24) return 24'd0;
            mag = {9'd1, w[22:0]} >> sh;
            return w[31] ? 24'(-mag) : mag[23:0];
        endfunction

        function void open_chunk();
            logic [31:0] remaining, frame, skip;
            bit          too_big;
            remaining = (pos <= file_len) ? file_len - pos : 32'd0;
            too_big = chunk_len > remaining || chunk_len > MAX_CHUNK;
            if (chunk_id == ID_FMT)
            begin
                if (too_big) abort(ERR_TOO_LARGE);
                else if (chunk_len == 0) abort(ERR_FMT_SHORT);
                else
                begin
                    left = chunk_len;
                    phase = P_FMT;
                end
            end
            else if (chunk_id == ID_DATA)
            begin
                frame = 32'(chans) * 32'(bits / 16'd8);
                if (!fmt_ok) abort(ERR_NO_FMT);
                else if (too_big) abort(ERR_TOO_LARGE);
                else if (chans == 0 || bits % 16'd8 != 0 || fmt_kind() == FMT_BAD
                         || frame == 0 || chunk_len % frame != 0)
                    abort(ERR_FORMAT);
                else
                begin
                    emit(KIND_INFO, 24'd0, 16'd0, 1, ERR_NONE);
                    sshift = 0; scount = 0; chan_ctr = 0;
                    if (chunk_len == 0)
                    begin
                        emit(KIND_DONE, 24'd0, 16'd0, 0, ERR_NONE);
                        phase = P_DONE;
                    end
                    else
                    begin
                        left = chunk_len;
                        phase = P_DATA;
                    end
                end
            end
            else
            begin
                skip = (chunk_len < remaining) ? chunk_len : remaining;
                pad = !too_big && chunk_len[0];
                if (skip == 0) body_done();
                else
                begin
                    left = skip;
                    phase = P_SKIP;
                end
            end
        endfunction

        function void fmt_field(logic [7:0] b);
            logic [31:0] off;
            off = chunk_len - left;
            case (off)
                0: afmt[7:0] = b;
                1: afmt[15:8] = b;
                2: chans[7:0] = b;
                3: chans[15:8] = b;
                4: rate[7:0] = b;
                5: rate[15:8] = b;
                6: rate[23:16] = b;
                7: rate[31:24] = b;
                14: bits[7:0] = b;
                15: bits[15:8] = b;
                default: ;
            endcase
        endfunction

        function void data_field(logic [7:0] b);
            logic [31:0] bps, cnt;
            logic [23:0] v;
            bps = 32'(bits / 16'd8);
            cnt = 32'(scount) + 1;
            sshift = sshift | (32'(b) << (8 * scount));
            if (cnt >= bps)
            begin
                case (fmt_kind())
                    FMT_PCM16: v = {sshift[15:0], 8'h00};
                    FMT_PCM24: v = sshift[23:0];
                    default:   v = float_q23(sshift);
                endcase
                emit(KIND_SAMPLE, v, chan_ctr, 0, ERR_NONE);
                chan_ctr++;
                if (chan_ctr >= chans) chan_ctr = 0;
                sshift = 0;
                scount = 0;
            end
            else
                scount = cnt[1:0];
            left--;
            if (left == 0)
            begin
                emit(KIND_DONE, 24'd0, 16'd0, 0, ERR_NONE);
                phase = P_DONE;
            end
        endfunction

        // one accepted byte transaction
        function void note_byte(logic [7:0] b, logic last);
            int       first;
            decoded_t t;
            first = owed.size();
            if (phase == P_DONE || phase == P_ERR) return;
            if (pos != 32'hFFFF_FFFF) pos++;
            case (phase)
                P_RIFF, P_RSIZE, P_WAVE:
                begin
                    hshift = {b, hshift[31:8]};
                    hcount++;
                    if (hcount >= 4)
                    begin
                        hcount = 0;
                        if (phase == P_RIFF)
                        begin
                            if (hshift != ID_RIFF) abort(ERR_RIFF);
                            else phase = P_RSIZE;
                        end
                        else if (phase == P_RSIZE)
                            phase = P_WAVE;
                        else if (hshift != ID_WAVE)
                            abort(ERR_WAVE);
                        else
                            phase = P_HDR;
                    end
                end
                P_HDR:
                begin
                    hshift = {b, hshift[31:8]};
                    hcount++;
                    if (hcount == 4) chunk_id = hshift;
                    if (hcount == 0)  // eight header bytes wrapped the 3-bit count
                    begin
                        chunk_len = hshift;
                        open_chunk();
                    end
                end
                P_FMT:
                begin
                    fmt_field(b);
                    left--;
                    if (left == 0)
                    begin
                        if (chunk_len < 16) abort(ERR_FMT_SHORT);
                        else
                        begin
                            fmt_ok = 1;
                            pad = chunk_len[0];
                            body_done();
                        end
                    end
                end
                P_DATA: data_field(b);
                P_SKIP:
                begin
                    left--;
                    if (left == 0) body_done();
                end
                P_PAD:
                begin
                    pad = 0;
                    hcount = 0;
                    phase = P_HDR;
                end
                default: phase = P_ERR;
            endcase
            if (last && phase != P_DONE && phase != P_ERR) abort(ERR_TRUNC);
            if (owed.size() > first)
            begin
                t = owed.pop_back();
                t.last = 1;
                owed.push_back(t);
            end
        endfunction

        // one accepted result transaction
        function void check_result(res_t got, logic got_last);
            decoded_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                $display("%0t: result mismatch expected none got %h/%b",
                         $time, got, got_last);
                return;
            end
            e = owed.pop_front();
            if (got !== e.r || got_last !== e.last)
            begin
                mismatches++;
                $display("%0t: result mismatch expected %h/%b got %h/%b",
                         $time, e.r, e.last, got, got_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    wsd_byte_if byte_bus ();
    wsd_res_if  res_bus ();
    wsd_cfg_if  cfg_bus ();

    wav_stream_sample_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_bus.sink),
        .result_stream (res_bus.source),
        .cfg_write     (cfg_bus.sink)
    );

    wav_scoreboard sb;
    int  cycles;
    bit  hold_request;
    int  hold_left;
    int  stall_left;
    logic [7:0] seg_hdr[$];
    logic [7:0] seg_fmt[$];
    logic [7:0] seg_data[$];

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // cycle count and timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check every transaction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_result({res_bus.result_kind, res_bus.sample_value, res_bus.channel_index,
                             res_bus.channel_count, res_bus.sample_rate, res_bus.sample_format,
                             res_bus.fault_code}, res_bus.last_in_run);
    end

    // result side back-pressure, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            res_bus.ready <= (stall_left == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            byte_bus.valid <= 1'b0;
        end
        @(negedge clk);
        byte_bus.valid <= 1'b1;
        byte_bus.byte_value <= b;
        byte_bus.last_byte <= last;
        do @(posedge clk); while (!byte_bus.ready);
        sb.note_byte(b, last);
    endtask

    task automatic send_segment(ref logic [7:0] seg[$], input bit mark_last);
        foreach (seg[i])
            send_byte(seg[i], mark_last && i == seg.size() - 1);
        @(negedge clk);
        byte_bus.valid <= 1'b0;
    endtask

    task automatic write_file_length(input logic [31:0] v);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.file_length_bytes <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        sb.file_len = v;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // wait until every owed result has arrived, then let the block settle
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void put_word(ref logic [7:0] seg[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            seg.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void put_sample(ref logic [7:0] seg[$], input logic [31:0] w,
                                       input int nbytes);
        for (int i = 0; i < nbytes; i++)
            seg.push_back(w[8 * i +: 8]);
    endfunction

    // float words spread over the interesting exponent range
    function automatic logic [31:0] random_float();
        logic [31:0] w;
        int r;
        w = $urandom;
        r = $urandom_range(0, 19);
        if (r < 14) w[30:23] = 8'($urandom_range(100, 130));
        else if (r == 14) w[30:23] = 8'hFF;
        else if (r == 15) w[30:23] = 8'h00;
        return w;
    endfunction

    initial
    begin
        int          fmt_sel, nch, bps, frames, total;
        logic [15:0] afmt_code, bits_code;
        logic [31:0] w;
        logic [31:0] edge_words[$];

        sb = new();
        cycles = 0;
        hold_request = 0;
        hold_left = 0;
        stall_left = 0;
        rst_n = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.byte_value = '0;
        byte_bus.last_byte = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.file_length_bytes = '0;
        res_bus.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pick the sample format and channel count of this file
        fmt_sel = $urandom_range(0, 2);
        nch = $urandom_range(1, 4);
        case (fmt_sel)
            0: begin afmt_code = 16'd1; bits_code = 16'd16; end
            1: begin afmt_code = 16'd1; bits_code = 16'd24; end
            default: begin afmt_code = 16'd3; bits_code = 16'd32; end
        endcase
        bps = bits_code / 8;
        frames = 700 / (bps * nch);

        // riff header, then a list chunk whose body vanishes while the length register is 0
        put_word(seg_hdr, ID_RIFF);
        put_word(seg_hdr, $urandom);
        put_word(seg_hdr, ID_WAVE);
        put_word(seg_hdr, 32'h5453_494C);
        put_word(seg_hdr, 32'h0000_0005);

        // decoy fmt, odd junk chunk with pad, real fmt of odd length with pad
        put_word(seg_fmt, ID_FMT);
        put_word(seg_fmt, 32'd18);
        put_word(seg_fmt, 32'h0002_0001);
        put_word(seg_fmt, 32'hFFFF_FFFF);
        put_word(seg_fmt, 32'h0);
        put_word(seg_fmt, 32'h0008_0000);
        seg_fmt.push_back(8'h00);
        seg_fmt.push_back(8'hFF);
        put_word(seg_fmt, 32'h4B4E_554A);
        put_word(seg_fmt, 32'd3);
        repeat (4) seg_fmt.push_back(8'($urandom));
        put_word(seg_fmt, ID_FMT);
        put_word(seg_fmt, 32'd17);
        put_word(seg_fmt, {16'(nch), afmt_code});
        put_word(seg_fmt, $urandom);
        put_word(seg_fmt, $urandom);
        put_word(seg_fmt, {bits_code, 16'($urandom)});
        seg_fmt.push_back(8'($urandom));
        seg_fmt.push_back(8'($urandom));

        // data chunk: edge samples first, then random content
        put_word(seg_data, ID_DATA);
        put_word(seg_data, 32'(frames * nch * bps));
        case (fmt_sel)
            0: edge_words = '{32'h7FFF, 32'h8000, 32'h0000, 32'hFFFF, 32'h0001};
            1: edge_words = '{32'h7FFFFF, 32'h800000, 32'h000000, 32'hFFFFFF, 32'h000001};
            default: edge_words = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
                                    32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001,
                                    32'h3380_0000, 32'h3F00_0000, 32'hBEFF_FFFF,
                                    32'h3F7F_FFFF, 32'h4000_0000, 32'h8000_0000};
        endcase
        for (int i = 0; i < frames * nch; i++)
        begin
            if (i < edge_words.size()) w = edge_words[i];
            else if (fmt_sel == 2) w = random_float();
            else w = $urandom;
            put_sample(seg_data, w, bps);
        end
        total = seg_hdr.size() + seg_fmt.size() + seg_data.size();

        write_file_length(32'h0);
        send_segment(seg_hdr, 0);
        drain();
        write_file_length(32'hFFFF_FFFF);
        send_segment(seg_fmt, 0);
        drain();
        // exact length, or a little slack; no chunk is too large either way
        write_file_length(32'(total) + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 1000)));
        hold_request = 1;
        send_segment(seg_data, 1);

        // bytes after the finish are ignored
        repeat (5) send_byte(8'($urandom), 1'($urandom));
        @(negedge clk);
        byte_bus.valid <= 1'b0;
        drain();

        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
